// File: rtl/clex_pkg.sv
//------------------------------------------------------------------------------
// clex_pkg
// Shared types, constants and byte classification for the C source lexer.
//------------------------------------------------------------------------------
`default_nettype none

package clex_pkg;

	localparam int TOKEN_MAX = 63;
	localparam int WHITE_MAX = 255;
	localparam int QDEPTH    = 4;
	localparam int QAW       = $clog2(QDEPTH);
	localparam int QCW       = $clog2(QDEPTH + 1);

	localparam logic [5:0] TOK_MAX_W   = 6'(TOKEN_MAX);
	localparam logic [7:0] WHITE_MAX_W = 8'(WHITE_MAX);

	localparam logic [2:0] TC_SYMBOL = 3'd0;
	localparam logic [2:0] TC_OPER   = 3'd1;
	localparam logic [2:0] TC_STRING = 3'd2;
	localparam logic [2:0] TC_CHAR   = 3'd3;
	localparam logic [2:0] TC_ARROW  = 3'd4;
	localparam logic [2:0] TC_MINUS  = 3'd5;
	localparam logic [2:0] TC_END    = 3'd6;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_TRUNC     = 3'd1;
	localparam logic [2:0] ERR_NL_STR    = 3'd2;
	localparam logic [2:0] ERR_NL_CHR    = 3'd3;
	localparam logic [2:0] ERR_EARLY_END = 3'd4;
	localparam logic [2:0] ERR_OVERSIZE  = 3'd5;

	localparam logic [7:0] CH_NL     = 8'h0a;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_LT     = 8'h3c;
	localparam logic [7:0] CH_GT     = 8'h3e;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_I      = 8'h69;

	typedef enum logic [2:0] {
		K_WHITE = 3'd0,
		K_SYM   = 3'd1,
		K_OPER  = 3'd2,
		K_STR   = 3'd3,
		K_CHR   = 3'd4,
		K_MINUS = 3'd5
	} kind_t;

	typedef enum logic [15:0] {
		M_WHITE   = 16'h0001,
		M_SLASH   = 16'h0002,
		M_CBODY   = 16'h0004,
		M_CSTAR   = 16'h0008,
		M_PSKIP1  = 16'h0010,
		M_PWORD   = 16'h0020,
		M_PSKIP2  = 16'h0040,
		M_PNAME   = 16'h0080,
		M_PREST   = 16'h0100,
		M_SYM     = 16'h0200,
		M_STR     = 16'h0400,
		M_STRESC  = 16'h0800,
		M_CHR     = 16'h1000,
		M_CHRESC1 = 16'h2000,
		M_CHRESC2 = 16'h4000,
		M_MINUS   = 16'h8000
	} mode_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [2:0] token_class;
		logic [7:0] operator_char;
		logic [5:0] token_length;
		logic [7:0] white_length;
		logic [2:0] error_code;
		logic       last_of_run;
	} out_item_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_input;
		kind_t      kind;
	} q_entry_t;

	typedef struct packed {
		mode_t      mode;
		logic [5:0] tcnt;
		logic [7:0] wcnt;
		logic [7:0] first;
		logic       snl;
		logic       ovf;
		logic [2:0] ppi;
		logic       ppgt;
		logic       rok;
	} lex_state_t;

	localparam lex_state_t LEX_CLEAR = '{M_WHITE, 6'd0, 8'd0, 8'd0, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0};

	function automatic kind_t kind_of(input logic [7:0] c);
		kind_t k;
		if (c <= CH_SPACE || c >= 8'h7f) begin
			k = K_WHITE;
		end else begin
			case (c) inside
				CH_DQUOTE: k = K_STR;
				CH_SQUOTE: k = K_CHR;
				CH_MINUS:  k = K_MINUS;
				8'h28, 8'h29, 8'h5b, 8'h5d, 8'h2c, 8'h3b, 8'h2a, 8'h23, 8'h3c, 8'h3e,
				8'h2b, 8'h2f, 8'h3a, 8'h3f, 8'h5e, 8'h7e, 8'h7c, 8'h26, 8'h21, 8'h25,
				8'h3d, 8'h7b, 8'h7d, 8'h2e: k = K_OPER;
				default: k = K_SYM;
			endcase
		end
		return k;
	endfunction

	// letters that must follow 'i' in an include directive
	function automatic logic [7:0] incl_char(input logic [2:0] i);
		logic [7:0] ch;
		case (i)
			3'd0:    ch = 8'h6e;
			3'd1:    ch = 8'h63;
			3'd2:    ch = 8'h6c;
			3'd3:    ch = 8'h75;
			3'd4:    ch = 8'h64;
			3'd5:    ch = 8'h65;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

// File: rtl/clex_front.sv
//------------------------------------------------------------------------------
// clex_front
// Accepts source words, tags each byte with its kind and queues it for the back.
//------------------------------------------------------------------------------
`default_nettype none

module clex_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                byte_valid,
	output logic                     byte_ready,
	input  wire clex_pkg::in_item_t  byte_data,
	output logic                     head_valid,
	output clex_pkg::q_entry_t       head,
	input  wire logic                head_pop
);
	import clex_pkg::*;

	q_entry_t       mem_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QCW-1:0] cnt_q;
	logic           push;
	logic           pop;

	assign byte_ready = cnt_q != QCW'(QDEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_q];
	assign push       = byte_valid && byte_ready;
	assign pop        = head_pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{byte_data.char_byte, byte_data.end_of_input,
				kind_of(byte_data.char_byte)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QAW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QAW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/clex_back.sv
//------------------------------------------------------------------------------
// clex_back
// Runs the lexer state machine on queued bytes and delivers token words.
//------------------------------------------------------------------------------
`default_nettype none

module clex_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                head_valid,
	input  wire clex_pkg::q_entry_t  head,
	output logic                     head_pop,
	output logic                     token_valid,
	input  wire logic                token_ready,
	output clex_pkg::out_item_t      token_data
);
	import clex_pkg::*;

	typedef struct packed {
		lex_state_t s;
		logic       em;
		out_item_t  r;
	} wb_t;

	lex_state_t st_q;
	lex_state_t st_nx;
	out_item_t  out_q;
	out_item_t  pend_q;
	logic       out_v_q;
	logic       pend_v_q;
	out_item_t  r0;
	out_item_t  r1;
	logic [1:0] n;
	logic       slot_free;

	function automatic logic [7:0] wsat(input logic [7:0] w);
		return (w != WHITE_MAX_W) ? w + 8'd1 : w;
	endfunction

	function automatic logic [5:0] tsat(input logic [5:0] t);
		return (t != TOK_MAX_W) ? t + 6'd1 : t;
	endfunction

	function automatic out_item_t mk_res(input logic [2:0] cls, input logic [7:0] ch,
		input logic [5:0] tlen, input logic [7:0] wl, input logic [2:0] err);
		out_item_t r;
		r.token_class   = cls;
		r.operator_char = ch;
		r.token_length  = tlen;
		r.white_length  = wl;
		r.error_code    = err;
		r.last_of_run   = 1'b0;
		return r;
	endfunction

	function automatic wb_t white_byte(input lex_state_t s, input logic [7:0] c,
		input kind_t k);
		wb_t o;
		o.s  = s;
		o.em = 1'b0;
		o.r  = mk_res(TC_END, 8'd0, 6'd0, 8'd0, ERR_NONE);
		if (k == K_WHITE) begin
			o.s.wcnt = wsat(s.wcnt);
		end else if (c == CH_SLASH) begin
			o.s.mode = M_SLASH;
		end else if (c == CH_HASH) begin
			o.s.wcnt = wsat(s.wcnt);
			o.s.mode = M_PSKIP1;
		end else begin
			case (k)
				K_OPER: begin
					o.em = 1'b1;
					o.r  = mk_res(TC_OPER, c, 6'd1, s.wcnt, ERR_NONE);
					o.s  = LEX_CLEAR;
				end
				K_STR: begin
					o.s.mode  = M_STR;
					o.s.first = c;
					o.s.tcnt  = 6'd1;
				end
				K_CHR: begin
					o.s.mode  = M_CHR;
					o.s.first = c;
					o.s.tcnt  = 6'd1;
				end
				K_MINUS: begin
					o.s.mode  = M_MINUS;
					o.s.first = c;
					o.s.tcnt  = 6'd1;
				end
				default: begin
					o.s.mode  = M_SYM;
					o.s.first = c;
					o.s.tcnt  = 6'd1;
					o.s.ovf   = 1'b0;
				end
			endcase
		end
		return o;
	endfunction

	function automatic lex_state_t after_word(input lex_state_t s, input logic [7:0] c,
		input kind_t k);
		lex_state_t o;
		o = s;
		if (k == K_WHITE) begin
			o.mode = M_PSKIP2;
		end else if (c == CH_DQUOTE) begin
			o.ppgt = 1'b0;
			o.mode = M_PNAME;
		end else if (c == CH_LT) begin
			o.ppgt = 1'b1;
			o.mode = M_PNAME;
		end else begin
			o.rok  = 1'b0;
			o.mode = M_PREST;
		end
		return o;
	endfunction

	always_comb begin
		logic [7:0] c;
		kind_t      k;
		logic [5:0] t;
		wb_t        wbo;
		c     = head.char_byte;
		k     = head.kind;
		t     = tsat(st_q.tcnt);
		wbo   = white_byte(LEX_CLEAR, c, k);
		st_nx = st_q;
		n     = 2'd0;
		r0    = mk_res(TC_END, 8'd0, 6'd0, 8'd0, ERR_NONE);
		r1    = r0;
		if (head.end_of_input) begin
			st_nx = LEX_CLEAR;
			if (st_q.mode == M_WHITE || (st_q.mode == M_PREST && st_q.rok)) begin
				r0 = mk_res(TC_END, 8'd0, 6'd0, st_q.wcnt, ERR_NONE);
				n  = 2'd1;
			end else if (st_q.mode == M_SYM) begin
				r0 = mk_res(TC_SYMBOL, st_q.first, st_q.tcnt, st_q.wcnt,
					st_q.ovf ? ERR_TRUNC : ERR_NONE);
				r1 = mk_res(TC_END, 8'd0, 6'd0, 8'd0, ERR_NONE);
				n  = 2'd2;
			end else begin
				r0 = mk_res(TC_END, 8'd0, 6'd0, st_q.wcnt, ERR_EARLY_END);
				n  = 2'd1;
			end
		end else begin
			case (st_q.mode)
				M_SLASH: begin
					if (c == CH_STAR) begin
						st_nx.wcnt = wsat(wsat(st_q.wcnt));
						st_nx.mode = M_CBODY;
					end else begin
						r0    = mk_res(TC_OPER, CH_SLASH, 6'd1, st_q.wcnt, ERR_NONE);
						st_nx = wbo.s;
						r1    = wbo.r;
						n     = wbo.em ? 2'd2 : 2'd1;
					end
				end
				M_CBODY: begin
					st_nx.wcnt = wsat(st_q.wcnt);
					if (c == CH_STAR) st_nx.mode = M_CSTAR;
				end
				M_CSTAR: begin
					st_nx.wcnt = wsat(st_q.wcnt);
					if (c == CH_SLASH) st_nx.mode = M_WHITE;
					else if (c != CH_STAR) st_nx.mode = M_CBODY;
				end
				M_PSKIP1: begin
					st_nx.wcnt = wsat(st_q.wcnt);
					if (k != K_WHITE) begin
						if (c == CH_I) begin
							st_nx.ppi  = 3'd0;
							st_nx.mode = M_PWORD;
						end else begin
							st_nx.rok  = 1'b0;
							st_nx.mode = M_PREST;
						end
					end
				end
				M_PWORD: begin
					st_nx.wcnt = wsat(st_q.wcnt);
					if (k == K_SYM) begin
						if (st_q.ppi < 3'd6) begin
							st_nx.ppi = (c == incl_char(st_q.ppi)) ? st_q.ppi + 3'd1 : 3'd7;
						end
					end else if (st_q.ppi == 3'd6) begin
						st_nx = after_word(st_nx, c, k);
					end else if (c == CH_NL) begin
						st_nx.mode = M_WHITE;
					end else begin
						st_nx.rok  = 1'b0;
						st_nx.mode = M_PREST;
					end
				end
				M_PSKIP2: begin
					st_nx.wcnt = wsat(st_q.wcnt);
					st_nx      = after_word(st_nx, c, k);
				end
				M_PNAME: begin
					st_nx.wcnt = wsat(st_q.wcnt);
					if (c <= CH_SPACE || c == (st_q.ppgt ? CH_GT : CH_DQUOTE)) begin
						if (c == CH_NL) begin
							st_nx.mode = M_WHITE;
						end else begin
							st_nx.rok  = 1'b1;
							st_nx.mode = M_PREST;
						end
					end
				end
				M_PREST: begin
					st_nx.wcnt = wsat(st_q.wcnt);
					if (c == CH_NL) begin
						st_nx.rok  = 1'b0;
						st_nx.mode = M_WHITE;
					end
				end
				M_SYM: begin
					if (k == K_SYM) begin
						if (st_q.tcnt >= TOK_MAX_W) st_nx.ovf = 1'b1;
						else st_nx.tcnt = st_q.tcnt + 6'd1;
					end else begin
						r0    = mk_res(TC_SYMBOL, st_q.first, st_q.tcnt, st_q.wcnt,
							st_q.ovf ? ERR_TRUNC : ERR_NONE);
						st_nx = wbo.s;
						r1    = wbo.r;
						n     = wbo.em ? 2'd2 : 2'd1;
					end
				end
				M_STR: begin
					st_nx.tcnt = t;
					if (c == CH_BSLASH) begin
						st_nx.mode = M_STRESC;
					end else if (c == CH_NL) begin
						st_nx.snl = 1'b1;
					end else if (c == CH_DQUOTE) begin
						r0 = mk_res(TC_STRING, st_q.first, t, st_q.wcnt,
							st_q.snl ? ERR_NL_STR : ((t >= TOK_MAX_W) ? ERR_OVERSIZE : ERR_NONE));
						n     = 2'd1;
						st_nx = LEX_CLEAR;
					end
				end
				M_STRESC: begin
					st_nx.tcnt = t;
					st_nx.mode = M_STR;
				end
				M_CHR, M_CHRESC2: begin
					st_nx.tcnt = t;
					if (c == CH_NL || c == CH_SQUOTE) begin
						r0 = mk_res(TC_CHAR, st_q.first, t, st_q.wcnt,
							(c == CH_NL) ? ERR_NL_CHR : ERR_NONE);
						n     = 2'd1;
						st_nx = LEX_CLEAR;
					end else if (st_q.mode == M_CHRESC2) begin
						st_nx.mode = M_CHR;
					end else if (c == CH_BSLASH) begin
						st_nx.mode = M_CHRESC1;
					end
				end
				M_CHRESC1: begin
					st_nx.tcnt = t;
					st_nx.mode = M_CHRESC2;
				end
				M_MINUS: begin
					if (c == CH_GT) begin
						r0    = mk_res(TC_ARROW, CH_MINUS, 6'd2, st_q.wcnt, ERR_NONE);
						n     = 2'd1;
						st_nx = LEX_CLEAR;
					end else begin
						r0    = mk_res(TC_MINUS, CH_MINUS, 6'd1, st_q.wcnt, ERR_NONE);
						st_nx = wbo.s;
						r1    = wbo.r;
						n     = wbo.em ? 2'd2 : 2'd1;
					end
				end
				default: begin
					wbo   = white_byte(st_q, c, k);
					st_nx = wbo.s;
					r0    = wbo.r;
					n     = wbo.em ? 2'd1 : 2'd0;
				end
			endcase
		end
		if (n == 2'd1) r0.last_of_run = 1'b1;
		if (n == 2'd2) r1.last_of_run = 1'b1;
	end

	assign slot_free   = !out_v_q || token_ready;
	assign head_pop    = head_valid && !pend_v_q && slot_free;
	assign token_valid = out_v_q;
	assign token_data  = out_q;

	always_ff @(posedge clk) begin
		if (head_pop) begin
			out_q  <= r0;
			pend_q <= r1;
		end else if (pend_v_q && slot_free) begin
			out_q <= pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= LEX_CLEAR;
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (head_pop) begin
				st_q     <= st_nx;
				out_v_q  <= n != 2'd0;
				pend_v_q <= n == 2'd2;
			end else if (pend_v_q && slot_free) begin
				out_v_q  <= 1'b1;
				pend_v_q <= 1'b0;
			end else if (token_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/c_source_lexer.sv
//------------------------------------------------------------------------------
// c_source_lexer
// Byte-stream tokenizer for C-like source text.
//------------------------------------------------------------------------------
// Feed one source byte per word on the byte channel (end_of_input set marks the
// end of the stream); token words come out on the token channel, each carrying
// its class, first or operator byte, saturated lengths, error code and a flag on
// the last token caused by a byte. The lexer takes one byte per cycle while its
// queue has room. The back-end state machine consumes one queued byte per cycle
// while its output can be written, and a byte that closes one token and emits
// another (an end of input after a symbol, or a byte that ends a symbol, slash
// or minus and is itself a one-byte operator other than slash or hash) holds
// the back end while its second token word leaves the output register. A
// four-entry queue between the classifier and the state machine absorbs those
// holds and stalls on the token side. Reset returns the lexer to white-space
// mode with all counts cleared.
//------------------------------------------------------------------------------
`default_nettype none

module c_source_lexer (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                byte_valid,
	output logic                     byte_ready,
	input  wire clex_pkg::in_item_t  byte_data,
	output logic                     token_valid,
	input  wire logic                token_ready,
	output clex_pkg::out_item_t      token_data
);
	import clex_pkg::*;

	logic     head_valid;
	logic     head_pop;
	q_entry_t head;

	clex_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop)
	);

	clex_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.head_pop    (head_pop),
		.token_valid (token_valid),
		.token_ready (token_ready),
		.token_data  (token_data)
	);

endmodule

`default_nettype wire

// File: tb/testbench.sv
//------------------------------------------------------------------------------
// testbench
// Self-checking bench for the C source lexer.
//------------------------------------------------------------------------------
// Feeds source bytes on the byte channel: a short directed run, then random
// source fragments. The fragments are white runs, symbols, operators, strings,
// char constants, arrows, comments, preprocessor lines and noise, and some are
// cut short by an end of input. A scoreboard class lexes every accepted byte
// itself and compares each token word field by field, in order. Both channels
// idle at random. The token side also holds off once for a long stretch, and
// the byte side waits once for the token stream to drain.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import clex_pkg::*;

	localparam int N_ITEMS     = 1650;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 16;
	localparam int CYCLE_LIMIT = 1000000;

	class token_scoreboard;
		out_item_t   tokens_due[$];
		int          mismatches;
		mode_t       mode;
		int          tcnt;
		int          wcnt;
		logic [7:0]  first;
		logic [7:0]  closer;
		bit          snl;
		bit          ovf;
		bit          rok;
		int          ppi;
		string       incl_word;

		function new();
			mismatches = 0;
			incl_word = "nclude";
			clear_scan();
		endfunction

		static function kind_t byte_kind(logic [7:0] c);
			string ops;
			ops = "()[],;*#<>+/:?^~|&!%={}.";
			if (c <= CH_SPACE || c >= 8'h7f) return K_WHITE;
			if (c == CH_DQUOTE) return K_STR;
			if (c == CH_SQUOTE) return K_CHR;
			if (c == CH_MINUS) return K_MINUS;
			for (int i = 0; i < ops.len(); i++)
				if (ops[i] == c) return K_OPER;
			return K_SYM;
		endfunction

		function void clear_scan();
			mode = M_WHITE;
			tcnt = 0;
			wcnt = 0;
			first = 8'h00;
			closer = 8'h00;
			snl = 0;
			ovf = 0;
			rok = 0;
			ppi = 0;
		endfunction

		function void add_white();
			if (wcnt < WHITE_MAX) wcnt++;
		endfunction

		function void add_tok();
			if (tcnt < TOKEN_MAX) tcnt++;
		endfunction

		function void put_token(logic [2:0] cls, logic [7:0] ch, int len, logic [2:0] err);
			out_item_t t;
			t.token_class = cls;
			t.operator_char = ch;
			t.token_length = len[5:0];
			t.white_length = wcnt[7:0];
			t.error_code = err;
			t.last_of_run = 1'b0;
			tokens_due.push_back(t);
			clear_scan();
		endfunction

		function void start_token(mode_t m, logic [7:0] c);
			mode = m;
			first = c;
			tcnt = 1;
		endfunction

		function void open_scan(logic [7:0] c);
			kind_t k;
			k = byte_kind(c);
			if (k == K_WHITE) begin
				add_white();
				return;
			end
			if (c == CH_SLASH) begin
				mode = M_SLASH;
				return;
			end
			if (c == CH_HASH) begin
				add_white();
				mode = M_PSKIP1;
				return;
			end
			case (k)
				K_OPER:  put_token(TC_OPER, c, 1, ERR_NONE);
				K_STR:   start_token(M_STR, c);
				K_CHR:   start_token(M_CHR, c);
				K_MINUS: start_token(M_MINUS, c);
				default: begin
					start_token(M_SYM, c);
					ovf = 0;
				end
			endcase
		endfunction

		function void after_word(logic [7:0] c);
			if (byte_kind(c) == K_WHITE) begin
				mode = M_PSKIP2;
			end else if (c == CH_DQUOTE) begin
				closer = CH_DQUOTE;
				mode = M_PNAME;
			end else if (c == CH_LT) begin
				closer = CH_GT;
				mode = M_PNAME;
			end else begin
				rok = 0;
				mode = M_PREST;
			end
		endfunction

		function void lex_byte(in_item_t w);
			int         before_n;
			out_item_t  t;
			logic [7:0] c;
			c = w.char_byte;
			before_n = tokens_due.size();
			if (w.end_of_input) begin
				if (mode == M_WHITE || (mode == M_PREST && rok)) begin
					put_token(TC_END, 8'h00, 0, ERR_NONE);
				end else if (mode == M_SYM) begin
					put_token(TC_SYMBOL, first, tcnt, ovf ? ERR_TRUNC : ERR_NONE);
					put_token(TC_END, 8'h00, 0, ERR_NONE);
				end else begin
					put_token(TC_END, 8'h00, 0, ERR_EARLY_END);
				end
			end else begin
				case (mode)
					M_SLASH: begin
						if (c == CH_STAR) begin
							add_white();
							add_white();
							mode = M_CBODY;
						end else begin
							put_token(TC_OPER, CH_SLASH, 1, ERR_NONE);
							open_scan(c);
						end
					end
					M_CBODY: begin
						add_white();
						if (c == CH_STAR) mode = M_CSTAR;
					end
					M_CSTAR: begin
						add_white();
						if (c == CH_SLASH) mode = M_WHITE;
						else if (c != CH_STAR) mode = M_CBODY;
					end
					M_PSKIP1: begin
						add_white();
						if (byte_kind(c) != K_WHITE) begin
							if (c == CH_I) begin
								ppi = 0;
								mode = M_PWORD;
							end else begin
								rok = 0;
								mode = M_PREST;
							end
						end
					end
					M_PWORD: begin
						add_white();
						if (byte_kind(c) == K_SYM) begin
							if (ppi < 6) ppi = (c == incl_word[ppi]) ? ppi + 1 : 7;
						end else if (ppi == 6) begin
							after_word(c);
						end else if (c == CH_NL) begin
							mode = M_WHITE;
						end else begin
							rok = 0;
							mode = M_PREST;
						end
					end
					M_PSKIP2: begin
						add_white();
						after_word(c);
					end
					M_PNAME: begin
						add_white();
						if (c <= CH_SPACE || c == closer) begin
							if (c == CH_NL) begin
								mode = M_WHITE;
							end else begin
								rok = 1;
								mode = M_PREST;
							end
						end
					end
					M_PREST: begin
						add_white();
						if (c == CH_NL) begin
							rok = 0;
							mode = M_WHITE;
						end
					end
					M_SYM: begin
						if (byte_kind(c) == K_SYM) begin
							if (tcnt >= TOKEN_MAX) ovf = 1;
							else tcnt++;
						end else begin
							put_token(TC_SYMBOL, first, tcnt, ovf ? ERR_TRUNC : ERR_NONE);
							open_scan(c);
						end
					end
					M_STR: begin
						add_tok();
						if (c == CH_BSLASH) mode = M_STRESC;
						else if (c == CH_NL) snl = 1;
						else if (c == CH_DQUOTE)
							put_token(TC_STRING, first, tcnt,
								snl ? ERR_NL_STR : (tcnt >= TOKEN_MAX ? ERR_OVERSIZE : ERR_NONE));
					end
					M_STRESC: begin
						add_tok();
						mode = M_STR;
					end
					M_CHR: begin
						add_tok();
						if (c == CH_BSLASH) mode = M_CHRESC1;
						else if (c == CH_NL) put_token(TC_CHAR, first, tcnt, ERR_NL_CHR);
						else if (c == CH_SQUOTE) put_token(TC_CHAR, first, tcnt, ERR_NONE);
					end
					M_CHRESC1: begin
						add_tok();
						mode = M_CHRESC2;
					end
					M_CHRESC2: begin
						add_tok();
						if (c == CH_NL) put_token(TC_CHAR, first, tcnt, ERR_NL_CHR);
						else if (c == CH_SQUOTE) put_token(TC_CHAR, first, tcnt, ERR_NONE);
						else mode = M_CHR;
					end
					M_MINUS: begin
						if (c == CH_GT) begin
							put_token(TC_ARROW, CH_MINUS, 2, ERR_NONE);
						end else begin
							put_token(TC_MINUS, CH_MINUS, 1, ERR_NONE);
							open_scan(c);
						end
					end
					default: open_scan(c);
				endcase
			end
			if (tokens_due.size() > before_n) begin
				t = tokens_due.pop_back();
				t.last_of_run = 1'b1;
				tokens_due.push_back(t);
			end
		endfunction

		function void flag(string what, out_item_t e, out_item_t g);
			mismatches++;
			if (mismatches <= 10)
				$display("%s: exp cls=%0d ch=%02h len=%0d wht=%0d err=%0d last=%0b / got cls=%0d ch=%02h len=%0d wht=%0d err=%0d last=%0b",
					what, e.token_class, e.operator_char, e.token_length, e.white_length,
					e.error_code, e.last_of_run, g.token_class, g.operator_char,
					g.token_length, g.white_length, g.error_code, g.last_of_run);
		endfunction

		function void check_token(out_item_t got);
			out_item_t e;
			if (tokens_due.size() == 0) begin
				flag("unexpected token word", '0, got);
				return;
			end
			e = tokens_due.pop_front();
			if (got.token_class !== e.token_class || got.operator_char !== e.operator_char ||
			    got.token_length !== e.token_length || got.white_length !== e.white_length ||
			    got.error_code !== e.error_code || got.last_of_run !== e.last_of_run)
				flag("token mismatch", e, got);
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       byte_valid;
	logic       byte_ready;
	in_item_t   byte_data;
	logic       token_valid;
	logic       token_ready;
	out_item_t  token_data;

	token_scoreboard sb;
	int         items_sent;
	int         cycle_count;
	int         hold_asked;
	bit         quiet;
	logic [7:0] frag[$];
	bit         frag_end;

	c_source_lexer uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.byte_data   (byte_data),
		.token_valid (token_valid),
		.token_ready (token_ready),
		.token_data  (token_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** c_source_lexer: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && byte_valid && byte_ready) sb.lex_byte(byte_data);
		if (arst_n === 1'b1 && token_valid === 1'b1 && token_ready) sb.check_token(token_data);
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(16, 40);
	endfunction

	function automatic logic [7:0] rand_sym_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(8'h21, 8'h7e));
		while (token_scoreboard::byte_kind(c) != K_SYM);
		return c;
	endfunction

	function automatic logic [7:0] rand_white_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return CH_SPACE;
		if (r < 65) return CH_NL;
		if (r < 75) return 8'h09;
		if (r < 88) return 8'($urandom_range(0, 8'h20));
		return 8'($urandom_range(8'h7f, 8'hff));
	endfunction

	function automatic logic [7:0] rand_body_byte(logic [7:0] skip_a, logic [7:0] skip_b);
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255));
		while (c == skip_a || c == skip_b);
		return c;
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++) frag.push_back(s[i]);
	endfunction

	function automatic void push_quoted(logic [7:0] quote, int n, int nl_pct);
		int r;
		frag.push_back(quote);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				frag.push_back(CH_BSLASH);
				frag.push_back(8'($urandom_range(0, 255)));
			end else if (r < 8 + nl_pct) begin
				frag.push_back(CH_NL);
			end else begin
				frag.push_back(rand_body_byte(quote, CH_BSLASH));
			end
		end
		frag.push_back(quote);
	endfunction

	function automatic void build_fragment();
		int    sel;
		int    n;
		int    r;
		string ops;
		ops = "()[],;*#<>+/:?^~|&!%={}.";
		frag.delete();
		frag_end = 0;
		sel = $urandom_range(0, 99);
		if (sel < 14) begin
			n = ($urandom_range(0, 99) < 2) ? $urandom_range(256, 300) : $urandom_range(1, 4);
			repeat (n) frag.push_back(rand_white_byte());
		end else if (sel < 30) begin
			n = ($urandom_range(0, 99) < 4) ? $urandom_range(60, 70) : $urandom_range(1, 8);
			repeat (n) frag.push_back(rand_sym_byte());
		end else if (sel < 42) begin
			frag.push_back(ops[$urandom_range(0, ops.len() - 1)]);
		end else if (sel < 54) begin
			n = ($urandom_range(0, 99) < 6) ? $urandom_range(60, 66) : $urandom_range(0, 8);
			push_quoted(CH_DQUOTE, n, 4);
		end else if (sel < 62) begin
			push_quoted(CH_SQUOTE, $urandom_range(0, 3), 10);
		end else if (sel < 70) begin
			frag.push_back(CH_MINUS);
			if ($urandom_range(0, 1)) frag.push_back(CH_GT);
		end else if (sel < 78) begin
			frag.push_back(CH_SLASH);
			if ($urandom_range(0, 4) != 0) begin
				frag.push_back(CH_STAR);
				n = $urandom_range(0, 10);
				repeat (n) frag.push_back($urandom_range(0, 3) == 0 ? CH_STAR : rand_body_byte(CH_SLASH, CH_STAR));
				push_text("*/");
			end
		end else if (sel < 90) begin
			frag.push_back(CH_HASH);
			repeat ($urandom_range(0, 2)) frag.push_back(rand_white_byte());
			r = $urandom_range(0, 99);
			if (r < 70) push_text("include");
			else if (r < 85) push_text("inclxde");
			else push_text("define");
			repeat ($urandom_range(0, 2)) frag.push_back($urandom_range(0, 1) ? CH_SPACE : 8'h09);
			r = $urandom_range(0, 2);
			if (r == 0) frag.push_back(CH_LT);
			if (r == 1) frag.push_back(CH_DQUOTE);
			repeat ($urandom_range(1, 6)) frag.push_back(rand_sym_byte());
			if (r == 0) frag.push_back(CH_GT);
			if (r == 1) frag.push_back(CH_DQUOTE);
			repeat ($urandom_range(0, 3))
				frag.push_back($urandom_range(0, 1) ? CH_SPACE : rand_body_byte(CH_NL, CH_NL));
			if ($urandom_range(0, 9) != 0) frag.push_back(CH_NL);
		end else begin
			repeat ($urandom_range(1, 3)) frag.push_back(8'($urandom_range(0, 255)));
		end
		r = $urandom_range(0, 99);
		if (r < 7) begin
			n = $urandom_range(0, frag.size());
			while (frag.size() > n) void'(frag.pop_back());
			frag_end = 1;
		end else if (r < 10) begin
			frag_end = 1;
		end
	endfunction

	task automatic send_word(input in_item_t w);
		int gap;
		quiet = (items_sent >= 1100 && items_sent < 1300);
		gap = idle_len();
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= w;
		@(posedge clk);
		while (!byte_ready) @(posedge clk);
		@(negedge clk);
		items_sent++;
		if (items_sent == 400) hold_asked++;
		if (items_sent == 900) begin
			byte_valid <= 1'b0;
			while (sb.tokens_due.size() != 0) @(posedge clk);
			@(negedge clk);
		end
	endtask

	task automatic send_char(input logic [7:0] c);
		send_word('{char_byte: c, end_of_input: 1'b0});
	endtask

	task automatic send_end();
		send_word('{char_byte: 8'($urandom_range(0, 255)), end_of_input: 1'b1});
	endtask

	// token side: random ready with one long hold-off
	initial begin
		int len;
		int hold_done;
		hold_done = 0;
		token_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_asked > hold_done) begin
				hold_done++;
				token_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			token_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(negedge clk);
			len = idle_len();
			if (len > 0) begin
				token_ready <= 1'b0;
				repeat (len) @(negedge clk);
			end
		end
	end

	initial begin
		string dtext;
		byte_valid = 1'b0;
		byte_data = '0;
		arst_n = 1'b0;
		items_sent = 0;
		cycle_count = 0;
		hold_asked = 0;
		quiet = 0;
		sb = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_char(8'h00);
		send_char(8'hff);
		send_char(8'h7f);
		send_char(CH_SPACE);
		dtext = "$z(->-/*c*/\"s\"'c'/#x\n";
		for (int i = 0; i < dtext.len(); i++) send_char(dtext[i]);
		send_end();

		while (items_sent < N_ITEMS) begin
			build_fragment();
			foreach (frag[i]) send_char(frag[i]);
			if (frag_end) send_end();
		end
		byte_valid <= 1'b0;

		while (sb.tokens_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("** c_source_lexer: PASSED **");
		else
			$display("** c_source_lexer: FAILED **");
		$finish;
	end

endmodule

// File: sim.f
rtl/clex_pkg.sv
rtl/clex_front.sv
rtl/clex_back.sv
rtl/c_source_lexer.sv
tb/testbench.sv
